// File: rtl/core/heart_rate_and_rmssd_tracker_top_macros.svh
// assertion macros shared by the tracker rtl
// no dependencies; included inside module bodies
`ifndef HEART_RATE_AND_RMSSD_TRACKER_TOP_MACROS_SVH
`define HEART_RATE_AND_RMSSD_TRACKER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define HRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrt assertion failed");

// next-cycle implication, checked outside reset
`define HRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrt assertion failed");

`endif

// File: rtl/core/hrt_pkg.sv
// shared constants and codes for the heart rate and rmssd tracker
// no dependencies
package hrt_pkg;

    // field widths
    localparam int IR_W     = 18;
    localparam int TIME_W   = 32;
    localparam int RR_W     = 12;
    localparam int EVT_W    = 3;
    localparam int OUT_W    = 16;
    localparam int CFG_W    = 18;
    localparam int CFG_IDX_W = 2;

    // default ring depth
    localparam int RR_DEPTH_DEF = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FINGER_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RR_UPPER   = 2'd2;

    // register reset values
    localparam logic [IR_W-1:0] FINGER_THR_RST = 18'd10000;
    localparam logic [RR_W-1:0] REFRACTORY_RST = 12'd300;
    localparam logic [RR_W-1:0] RR_UPPER_RST   = 12'd2000;

    // 60000 * 256
    localparam logic [TIME_W-1:0] BPM_NUM_Q8 = 32'd15360000;

    // event codes
    localparam logic [EVT_W-1:0] EVT_NO_FINGER = 3'd0;
    localparam logic [EVT_W-1:0] EVT_NO_BEAT   = 3'd1;
    localparam logic [EVT_W-1:0] EVT_FIRST     = 3'd2;
    localparam logic [EVT_W-1:0] EVT_TOO_FAST  = 3'd3;
    localparam logic [EVT_W-1:0] EVT_MEASURED  = 3'd4;

endpackage

// File: rtl/core/heart_rate_and_rmssd_tracker_top.sv
// heart rate and rmssd tracker: one result beat per sample beat
// depends on hrt_pkg and heart_rate_and_rmssd_tracker_top_macros.svh
//
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// sample   | i_valid / o_stall  | i_ir_level, i_beat_seen, i_time_ms
// result   | o_valid / i_stall  | o_event_res, o_bpm_q8, o_hrv_valid, o_rmssd_q4
// config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// no finger, no beat, first beat and too-fast samples go from evaluation to the output stage
// a measured beat runs the divider for bpm, then, with two or more stored intervals, walks
// the ring, divides again and takes the root; the shared bit-serial divider is D bits wide
// (36 at the default depth of 10)
// reset is synchronous and needs no clearing pass; the ring stays unwritten
// a stalled result waits in the output register; the next sample is taken meanwhile
module heart_rate_and_rmssd_tracker_top #(
    parameter int RR_DEPTH = hrt_pkg::RR_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hrt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hrt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [hrt_pkg::IR_W-1:0]      i_ir_level,
    input  logic                          i_beat_seen,
    input  logic [hrt_pkg::TIME_W-1:0]    i_time_ms,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hrt_pkg::EVT_W-1:0]     o_event_res,
    output logic [hrt_pkg::OUT_W-1:0]     o_bpm_q8,
    output logic                          o_hrv_valid,
    output logic [hrt_pkg::OUT_W-1:0]     o_rmssd_q4
);
    import hrt_pkg::*;

    localparam int PW     = (RR_DEPTH > 1) ? $clog2(RR_DEPTH) : 1;
    localparam int FW     = $clog2(RR_DEPTH + 1);
    localparam int SQ_W   = 2 * RR_W + $clog2(RR_DEPTH);
    localparam int NUM2_W = SQ_W + 8;
    localparam int DN_W0  = (NUM2_W > TIME_W) ? NUM2_W : TIME_W;
    localparam int DN_W   = DN_W0 + (DN_W0 % 2);
    localparam int RT_W   = DN_W / 2;
    localparam int CW     = $clog2(DN_W + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_WRD  = 3'd3;
    localparam logic [2:0] ST_WAC  = 3'd4;
    localparam logic [2:0] ST_DIV2 = 3'd5;
    localparam logic [2:0] ST_SQRT = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0]        r_state;
    logic [IR_W-1:0]   r_thr;
    logic [RR_W-1:0]   r_refr;
    logic [RR_W-1:0]   r_upper;
    logic [IR_W-1:0]   r_ir;
    logic              r_beat;
    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] r_last;
    logic              r_have;
    logic [PW-1:0]     r_wpos;
    logic [FW-1:0]     r_fill;
    logic [RR_W-1:0]   r_mem [RR_DEPTH];
    logic [PW-1:0]     r_rp;
    logic [RR_W-1:0]   r_rd;
    logic [FW-1:0]     r_k;
    logic [RR_W-1:0]   r_prev;
    logic [SQ_W-1:0]   r_acc;
    logic [DN_W-1:0]   r_dnum;
    logic [TIME_W-1:0] r_dden;
    logic [TIME_W-1:0] r_drem;
    logic [CW-1:0]     r_cnt;
    logic [RT_W+1:0]   r_sqrem;
    logic [RT_W-1:0]   r_root;
    logic [EVT_W-1:0]  r_evt;
    logic [OUT_W-1:0]  r_bpm;
    logic              r_hrv;
    logic [OUT_W-1:0]  r_rmssd;
    logic              r_ovalid;
    logic [EVT_W-1:0]  r_oevt;
    logic [OUT_W-1:0]  r_obpm;
    logic              r_ohrv;
    logic [OUT_W-1:0]  r_ormssd;

    logic [TIME_W-1:0] n_dt;
    logic              n_store;
    logic [TIME_W:0]   n_trial;
    logic              n_ge;
    logic [TIME_W:0]   n_diff;
    logic [TIME_W-1:0] n_drem;
    logic [DN_W-1:0]   n_dnum;
    logic [RT_W+3:0]   n_sqt;
    logic [RT_W+3:0]   n_sqtv;
    logic              n_sqge;
    logic [RT_W+1:0]   n_sqrem;
    logic [RT_W-1:0]   n_root;
    logic [RR_W-1:0]   n_d;
    logic [2*RR_W-1:0] n_sq;
    logic [SQ_W-1:0]   n_acc;
    logic              n_oload;

    // interval and ring window check
    assign n_dt    = r_time - r_last;
    assign n_store = (n_dt > TIME_W'(r_refr)) && (n_dt < TIME_W'(r_upper));

    // one quotient bit per cycle
    assign n_trial = {r_drem, r_dnum[DN_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_dden};
    assign n_diff  = n_trial - {1'b0, r_dden};
    assign n_drem  = n_ge ? n_diff[TIME_W-1:0] : n_trial[TIME_W-1:0];
    assign n_dnum  = {r_dnum[DN_W-2:0], n_ge};

    // one root bit per cycle, two radicand bits shifted in
    assign n_sqt   = {r_sqrem, r_dnum[DN_W-1:DN_W-2]};
    assign n_sqtv  = (RT_W+4)'({r_root, 2'b01});
    assign n_sqge  = n_sqt >= n_sqtv;
    assign n_sqrem = n_sqge ? (RT_W+2)'(n_sqt - n_sqtv) : n_sqt[RT_W+1:0];
    assign n_root  = {r_root[RT_W-2:0], n_sqge};

    // squared successive difference
    assign n_d   = (r_rd >= r_prev) ? (r_rd - r_prev) : (r_prev - r_rd);
    assign n_sq  = n_d * n_d;
    assign n_acc = (r_k == '0) ? r_acc : (r_acc + SQ_W'(n_sq));

    assign n_oload = !r_ovalid || !i_stall;

    // ring write and registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL && r_ir >= r_thr && r_beat
                && r_have && n_dt >= TIME_W'(r_refr) && n_store) begin
            r_mem[r_wpos] <= n_dt[RR_W-1:0];
        end
        r_rd <= r_mem[r_rp];
    end

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_thr    <= FINGER_THR_RST;
            r_refr   <= REFRACTORY_RST;
            r_upper  <= RR_UPPER_RST;
            r_last   <= '0;
            r_have   <= 1'b0;
            r_wpos   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FINGER_THR: r_thr   <= i_cfg_data;
                    CFG_REFRACTORY: r_refr  <= i_cfg_data[RR_W-1:0];
                    CFG_RR_UPPER:   r_upper <= i_cfg_data[RR_W-1:0];
                    default: ;
                endcase
            end

            if (r_ovalid && !i_stall && r_state != ST_FIN) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_ir    <= i_ir_level;
                        r_beat  <= i_beat_seen;
                        r_time  <= i_time_ms;
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_bpm   <= '0;
                    r_hrv   <= 1'b0;
                    r_rmssd <= '0;
                    priority if (r_ir < r_thr) begin
                        r_evt   <= EVT_NO_FINGER;
                        r_last  <= '0;
                        r_have  <= 1'b0;
                        r_wpos  <= '0;
                        r_fill  <= '0;
                        r_state <= ST_FIN;
                    end else if (!r_beat) begin
                        r_evt   <= EVT_NO_BEAT;
                        r_state <= ST_FIN;
                    end else if (!r_have) begin
                        r_evt   <= EVT_FIRST;
                        r_have  <= 1'b1;
                        r_last  <= r_time;
                        r_state <= ST_FIN;
                    end else if (n_dt < TIME_W'(r_refr)) begin
                        r_evt   <= EVT_TOO_FAST;
                        r_state <= ST_FIN;
                    end else begin
                        r_evt   <= EVT_MEASURED;
                        r_last  <= r_time;
                        r_dnum  <= DN_W'(BPM_NUM_Q8 + (n_dt >> 1));
                        r_dden  <= n_dt;
                        r_drem  <= '0;
                        r_cnt   <= '0;
                        if (n_store) begin
                            r_wpos <= (r_wpos == PW'(RR_DEPTH - 1)) ? '0 : r_wpos + 1'b1;
                            if (r_fill < FW'(RR_DEPTH)) begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end
                        r_state <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    r_dnum <= n_dnum;
                    r_drem <= n_drem;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DN_W - 1)) begin
                        r_bpm <= (|n_dnum[DN_W-1:OUT_W]) ? '1 : n_dnum[OUT_W-1:0];
                        r_rp  <= (r_fill < FW'(RR_DEPTH)) ? '0 : r_wpos;
                        r_k   <= '0;
                        r_acc <= '0;
                        r_state <= (r_fill >= FW'(2)) ? ST_WRD : ST_FIN;
                    end
                end
                ST_WRD: begin
                    r_state <= ST_WAC;
                end
                ST_WAC: begin
                    r_prev <= r_rd;
                    r_acc  <= n_acc;
                    r_k    <= r_k + 1'b1;
                    r_rp   <= (r_rp == PW'(RR_DEPTH - 1)) ? '0 : r_rp + 1'b1;
                    if (r_k == r_fill - 1'b1) begin
                        r_dnum  <= DN_W'({n_acc, 8'b0});
                        r_dden  <= TIME_W'(r_fill - 1'b1);
                        r_drem  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIV2;
                    end else begin
                        r_state <= ST_WRD;
                    end
                end
                ST_DIV2: begin
                    r_dnum <= n_dnum;
                    r_drem <= n_drem;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DN_W - 1)) begin
                        r_sqrem <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_dnum  <= {r_dnum[DN_W-3:0], 2'b00};
                    r_sqrem <= n_sqrem;
                    r_root  <= n_root;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CW'(RT_W - 1)) begin
                        r_rmssd <= (|n_root[RT_W-1:OUT_W]) ? '1 : n_root[OUT_W-1:0];
                        r_hrv   <= 1'b1;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (n_oload) begin
                        r_ovalid <= 1'b1;
                        r_oevt   <= r_evt;
                        r_obpm   <= r_bpm;
                        r_ohrv   <= r_hrv;
                        r_ormssd <= r_rmssd;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_event_res = r_oevt;
    assign o_bpm_q8    = r_obpm;
    assign o_hrv_valid = r_ohrv;
    assign o_rmssd_q4  = r_ormssd;

    `include "heart_rate_and_rmssd_tracker_top_macros.svh"

    `HRT_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(RR_DEPTH))
    `HRT_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, i_valid && !o_stall, r_state == ST_EVAL)
    `HRT_ASSERT_NOW(a_hrv_measured, i_clk, i_rst_n, o_valid && o_hrv_valid, o_event_res == EVT_MEASURED)
    `HRT_ASSERT_NOW(a_bpm_idle, i_clk, i_rst_n, o_valid && o_event_res != EVT_MEASURED, o_bpm_q8 == '0 && !o_hrv_valid)

endmodule

// File: tb/sv/tb_heart_rate_and_rmssd_tracker_top.sv
// testbench for heart_rate_and_rmssd_tracker_top: random and directed samples
// depends on hrt_pkg and the tracker rtl; predicts bpm and rmssd per sample beat
`timescale 1ns / 1ps

module tb_heart_rate_and_rmssd_tracker_top;
    import hrt_pkg::*;

    localparam int DEPTH = RR_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [EVT_W-1:0] evt;
        logic [OUT_W-1:0] bpm;
        logic             hrv;
        logic [OUT_W-1:0] rmssd;
    } t_pulse_res;

    int fail_count = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // predictor and queue of expected result beats
    class t_pulse_scoreboard;
        logic [IR_W-1:0]   thr_reg;
        logic [RR_W-1:0]   refr_reg;
        logic [RR_W-1:0]   upper_reg;
        logic [TIME_W-1:0] last_time;
        bit                have_last;
        logic [RR_W-1:0]   ring [DEPTH];
        int                wr_pos;
        int                fill;
        t_pulse_res        pending [$];

        function void clear_state();
            last_time = '0;
            have_last = 0;
            wr_pos = 0;
            fill = 0;
        endfunction

        function new();
            thr_reg = FINGER_THR_RST;
            refr_reg = REFRACTORY_RST;
            upper_reg = RR_UPPER_RST;
            clear_state();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_FINGER_THR) thr_reg = val[IR_W-1:0];
            else if (idx == CFG_REFRACTORY) refr_reg = val[RR_W-1:0];
            else if (idx == CFG_RR_UPPER) upper_reg = val[RR_W-1:0];
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r;
            r = 0;
            for (int b = 31; b >= 0; b--)
                if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
            return r;
        endfunction

        function logic [OUT_W-1:0] rmssd_of_ring();
            longint unsigned sumsq, d, r;
            int start, prev, cur;
            start = (fill < DEPTH) ? 0 : wr_pos;
            sumsq = 0;
            prev = ring[start % DEPTH];
            for (int k = 1; k < fill; k++) begin
                cur = ring[(start + k) % DEPTH];
                d = (cur >= prev) ? cur - prev : prev - cur;
                sumsq += d * d;
                prev = cur;
            end
            r = isqrt((sumsq * 256) / (fill - 1));
            return (r > 65535) ? 16'hFFFF : r[OUT_W-1:0];
        endfunction

        // note an accepted sample beat
        function void note_sample(logic [IR_W-1:0] ir, logic beat, logic [TIME_W-1:0] now);
            t_pulse_res res;
            logic [TIME_W-1:0] dt;
            longint unsigned bpm;
            res = '{evt: EVT_NO_BEAT, bpm: 0, hrv: 0, rmssd: 0};
            if (ir < thr_reg) begin
                clear_state();
                res.evt = EVT_NO_FINGER;
            end else if (beat) begin
                if (!have_last) begin
                    have_last = 1;
                    last_time = now;
                    res.evt = EVT_FIRST;
                end else begin
                    dt = now - last_time;
                    if (dt < refr_reg) res.evt = EVT_TOO_FAST;
                    else begin
                        if (dt == 0) bpm = 65535;
                        else bpm = (64'(BPM_NUM_Q8) + (dt >> 1)) / dt;
                        if (bpm > 65535) bpm = 65535;
                        res.evt = EVT_MEASURED;
                        res.bpm = bpm[OUT_W-1:0];
                        if (dt > refr_reg && dt < upper_reg) begin
                            ring[wr_pos] = dt[RR_W-1:0];
                            wr_pos = (wr_pos + 1) % DEPTH;
                            if (fill < DEPTH) fill++;
                        end
                        if (fill >= 2) begin
                            res.hrv = 1;
                            res.rmssd = rmssd_of_ring();
                        end
                        last_time = now;
                    end
                end
            end
            pending.push_back(res);
        endfunction

        // compare one accepted result beat with the oldest expectation
        task check_result(t_pulse_res got);
            t_pulse_res want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result beat", got.evt, -1);
                return;
            end
            want = pending.pop_front();
            if (got.evt !== want.evt) report_mismatch("event_res", got.evt, want.evt);
            if (got.bpm !== want.bpm) report_mismatch("bpm_q8", got.bpm, want.bpm);
            if (got.hrv !== want.hrv) report_mismatch("hrv_valid", got.hrv, want.hrv);
            if (got.rmssd !== want.rmssd) report_mismatch("rmssd_q4", got.rmssd, want.rmssd);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [IR_W-1:0]      i_ir_level;
    logic                 i_beat_seen;
    logic [TIME_W-1:0]    i_time_ms;
    logic                 o_valid;
    logic                 i_stall = 1'b1;
    logic [EVT_W-1:0]     o_event_res;
    logic [OUT_W-1:0]     o_bpm_q8;
    logic                 o_hrv_valid;
    logic [OUT_W-1:0]     o_rmssd_q4;

    t_pulse_scoreboard sb = new();
    int send_idle_pct = 20;
    int recv_stall_pct = 50;
    logic [TIME_W-1:0] clock_ms = 32'd1000;

    heart_rate_and_rmssd_tracker_top DUT (.*);

    // clock
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver stall and result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{evt: o_event_res, bpm: o_bpm_q8, hrv: o_hrv_valid,
                              rmssd: o_rmssd_q4});
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // cycle limit
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL heart_rate_and_rmssd_tracker_top");
            $finish;
        end
    end

    // send one sample beat, with random idle cycles before it
    task automatic send_sample(input logic [IR_W-1:0] ir, input logic beat,
                               input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ir_level <= ir;
        i_beat_seen <= beat;
        i_time_ms <= now;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(ir, beat, now);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // finger-on sample, beat with a given interval from the running clock
    task automatic beat_after(input int gap);
        clock_ms = clock_ms + gap;
        send_sample(18'($urandom_range(262143, 40000)), 1'b1, clock_ms);
    endtask

    // one random sample: mostly rhythmic beats, some noise and finger loss
    task automatic random_sample(input int upper);
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) beat_after($urandom_range(upper, 250));
        else if (pick < 72) beat_after($urandom_range(400, 0));
        else if (pick < 85) begin
            clock_ms = clock_ms + $urandom_range(100);
            send_sample(18'($urandom), 1'b0, clock_ms);
        end else if (pick < 92) send_sample(18'($urandom_range(9999)), 1'($urandom), $urandom);
        else if (pick < 96) beat_after($urandom_range(4095));
        else send_sample(18'($urandom), 1'($urandom), $urandom);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_FINGER_THR;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ir_level = '0;
        i_beat_seen = 1'b0;
        i_time_ms = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every event, wrap and huge intervals
        send_sample(18'd0, 1'b1, 32'hFFFF_FFFF);
        send_sample(18'h3FFFF, 1'b0, 32'd0);
        send_sample(18'd9999, 1'b1, 32'd5);
        send_sample(18'd10000, 1'b1, 32'hFFFF_FF00);
        send_sample(18'h3FFFF, 1'b1, 32'hFFFF_FF10);
        send_sample(18'h3FFFF, 1'b1, 32'h0000_0200);
        send_sample(18'h2AAAA, 1'b1, 32'h0000_0500);
        send_sample(18'h15555, 1'b1, 32'h0000_07D0);
        send_sample(18'h3FFFF, 1'b1, 32'h0000_0AF0);
        send_sample(18'h3FFFF, 1'b1, 32'h8000_0AF0);
        send_sample(18'h3FFFF, 1'b1, 32'h5555_5555);
        send_sample(18'h3FFFF, 1'b1, 32'hAAAA_AAAA);
        clock_ms = 32'hAAAA_AAAA;
        repeat (12) beat_after($urandom_range(1999, 301));
        wait_drained();

        // zero interval and tiny intervals with no refractory time
        write_cfg(CFG_REFRACTORY, 18'd0);
        write_cfg(CFG_RR_UPPER, 18'd4095);
        write_cfg(CFG_FINGER_THR, 18'd0);
        beat_after(0);
        beat_after(0);
        beat_after(1);
        beat_after(2);
        beat_after(4094);
        beat_after(1);
        repeat (150) random_sample(4095);
        wait_drained();

        // refractory at maximum, upper at one, threshold at maximum
        write_cfg(CFG_REFRACTORY, 18'd4095);
        write_cfg(CFG_RR_UPPER, 18'd1);
        write_cfg(CFG_FINGER_THR, 18'h3FFFF);
        repeat (20) send_sample(18'($urandom), 1'($urandom), $urandom);
        beat_after(5000);
        beat_after(4095);
        beat_after(4096);
        wait_drained();

        // defaults again, other idle mix
        write_cfg(CFG_FINGER_THR, 18'd10000);
        write_cfg(CFG_REFRACTORY, 18'd300);
        write_cfg(CFG_RR_UPPER, 18'd2000);
        send_idle_pct = 50;
        recv_stall_pct = 20;
        repeat (150) random_sample(2200);
        wait_drained();

        write_cfg(CFG_REFRACTORY, 18'd500);
        write_cfg(CFG_RR_UPPER, 18'd1200);
        write_cfg(CFG_FINGER_THR, 18'd20000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (130) random_sample(1400);
        wait_drained();

        if (fail_count == 0 && sb.pending.size() == 0)
            $display("PASS heart_rate_and_rmssd_tracker_top");
        else
            $display("FAIL heart_rate_and_rmssd_tracker_top");
        $finish;
    end

endmodule
